// ----- src/timed_claw_motor_sequencer_top_defines.svh -----
// Assertion macros for the timed claw motor sequencer.
// Used by the modules in src that carry concurrent assertions.
`ifndef TIMED_CLAW_MOTOR_SEQUENCER_TOP_DEFINES_SVH
`define TIMED_CLAW_MOTOR_SEQUENCER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset
`define TCMS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tcms assertion failed");

// Next-cycle implication, checked out of reset
`define TCMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tcms assertion failed");

`else

`define TCMS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TCMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/tcms_pkg.sv -----
// Shared types and codes for the timed claw motor sequencer.
// No dependencies; imported by every module in src.
package tcms_pkg;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int DUR_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_DURATION  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_DURATION = 2'd1;

    // Item function codes
    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_OPEN    = 2'd1,
        FUNC_CLOSE   = 2'd2,
        FUNC_DISABLE = 2'd3
    } t_func;

    // Error codes
    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_KILL    = 2'd1,
        ERR_INVALID = 2'd2
    } t_err;

    // Claw position codes
    typedef enum logic [2:0] {
        POS_ERROR    = 3'd0,
        POS_DISARMED = 3'd1,
        POS_UNKNOWN  = 3'd2,
        POS_OPENED   = 3'd3,
        POS_CLOSED   = 3'd4,
        POS_OPENING  = 3'd5,
        POS_CLOSING  = 3'd6
    } t_pos;

    // Input word
    typedef struct packed {
        logic [1:0] func;
        logic       kill_asserted;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic       ok;
        logic [1:0] error_code;
        logic [2:0] position_report;
        logic       busy_res;
        logic       motor_enable;
        logic       motor_forward;
    } t_out_word;

    // Configured durations
    typedef struct packed {
        logic [DUR_W-1:0] open_ms;
        logic [DUR_W-1:0] close_ms;
    } t_cfg;

    // Sequencer state
    typedef struct packed {
        t_pos             pos;
        logic [DUR_W-1:0] remaining_ms;
    } t_claw_state;

endpackage

// ----- src/tcms_cfg_regs.sv -----
// Duration configuration registers of the claw sequencer.
// Depends on tcms_pkg.
module tcms_cfg_regs import tcms_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DUR_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // Writes are always taken
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register file; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OPEN_DURATION:  r_cfg.open_ms  <= i_cfg_data;
                CFG_CLOSE_DURATION: r_cfg.close_ms <= i_cfg_data;
                default:            r_cfg          <= r_cfg;
            endcase
        end
    end

endmodule

// ----- src/tcms_step.sv -----
// Next-state and result logic for one sequencer word.
// Depends on tcms_pkg; purely combinational.
module tcms_step import tcms_pkg::*; (
    input  t_in_word    i_word,
    input  t_claw_state i_state,
    input  t_cfg        i_cfg,
    output t_claw_state o_state,
    output t_out_word   o_result
);

    always_comb begin
        logic             unset;
        logic             opening;
        logic             moving_now;
        logic [DUR_W-1:0] rem_dec;
        t_pos             here;
        t_pos             there;
        t_pos             goal;
        t_pos             from;
        t_err             err;
        t_claw_state      nxt;

        unset      = (i_cfg.open_ms == '0) || (i_cfg.close_ms == '0);
        here       = unset ? POS_ERROR : i_state.pos;
        moving_now = (i_state.pos == POS_OPENING) || (i_state.pos == POS_CLOSING);
        rem_dec    = (i_state.remaining_ms != '0) ? (i_state.remaining_ms - DUR_W'(1)) : '0;
        opening    = (t_func'(i_word.func) == FUNC_OPEN);
        there      = opening ? POS_OPENED  : POS_CLOSED;
        goal       = opening ? POS_OPENING : POS_CLOSING;
        from       = opening ? POS_CLOSED  : POS_OPENED;
        err        = ERR_NONE;
        nxt        = i_state;

        case (t_func'(i_word.func))
            FUNC_TICK: begin
                // Count down; finish the move when the count hits zero
                if (moving_now) begin
                    nxt.remaining_ms = rem_dec;
                    if (rem_dec == '0) begin
                        nxt.pos = (i_state.pos == POS_OPENING) ? POS_OPENED : POS_CLOSED;
                    end
                end
            end
            FUNC_OPEN, FUNC_CLOSE: begin
                if (i_word.kill_asserted) begin
                    err = ERR_KILL;
                end else if (here == there || here == goal) begin
                    err = ERR_NONE;
                end else if (here != POS_UNKNOWN && here != from) begin
                    err = ERR_INVALID;
                end else begin
                    nxt.pos          = goal;
                    nxt.remaining_ms = opening ? i_cfg.open_ms : i_cfg.close_ms;
                end
            end
            default: begin
                // Safety disable: abort any move
                if (moving_now) begin
                    nxt.pos          = POS_UNKNOWN;
                    nxt.remaining_ms = '0;
                end
            end
        endcase

        o_state                  = nxt;
        o_result.ok              = (err == ERR_NONE);
        o_result.error_code      = err;
        o_result.position_report = unset ? POS_ERROR : nxt.pos;
        o_result.busy_res        = (nxt.pos == POS_OPENING) || (nxt.pos == POS_CLOSING);
        o_result.motor_enable    = (nxt.pos == POS_OPENING) || (nxt.pos == POS_CLOSING);
        o_result.motor_forward   = (nxt.pos == POS_OPENING);
    end

endmodule

// ----- src/tcms_core.sv -----
// Input register, claw state and result register of the sequencer.
// Depends on tcms_pkg, tcms_step and the assertion macro header.
`include "timed_claw_motor_sequencer_top_defines.svh"

module tcms_core import tcms_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    logic        r_in_valid;
    t_in_word    r_in_word;
    t_claw_state r_state;
    t_claw_state n_state;
    logic        r_out_valid;
    t_out_word   r_out_word;
    t_out_word   n_out_word;
    logic        out_free;
    logic        fire;

    // Handshake: the word in the input register moves on when the result slot frees
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    tcms_step u_step (
        .i_word   (r_in_word),
        .i_state  (r_state),
        .i_cfg    (i_cfg),
        .o_state  (n_state),
        .o_result (n_out_word)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    // Claw state, updated once per processed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.pos          <= POS_UNKNOWN;
            r_state.remaining_ms <= '0;
        end else if (fire) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (fire) begin
            r_out_word <= n_out_word;
        end
    end

    `TCMS_ASSERT_NOW(a_pos_reachable, i_clk, i_rst_n, 1'b1, (r_state.pos != POS_ERROR && r_state.pos != POS_DISARMED))
    `TCMS_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, fire, r_out_valid)
    `TCMS_ASSERT_NEXT(a_state_holds_idle, i_clk, i_rst_n, !fire, $stable(r_state))
    `TCMS_ASSERT_NOW(a_ok_matches_err, i_clk, i_rst_n, r_out_valid, (r_out_word.ok == (r_out_word.error_code == ERR_NONE)))
    `TCMS_ASSERT_NOW(a_forward_needs_enable, i_clk, i_rst_n, (r_out_valid && r_out_word.motor_forward), r_out_word.motor_enable)

endmodule

// ----- src/timed_claw_motor_sequencer_top.sv -----
// Timed claw motor sequencer: an open-loop H-bridge claw controller. Each input word is a
// 1 ms tick or an open, close or safety-disable command plus the kill switch level, and
// yields one result word with status, reported position and the H-bridge drive levels.
// A word passes through the input register, then the result register, and one word is
// accepted every cycle unless the result register is stalled; the state update of the
// position and the 16-bit millisecond countdown sets that rate. Durations are written
// through the configuration port, which is always ready; a zero duration reports the
// error position and refuses open and close.
// Depends on tcms_pkg, tcms_cfg_regs and tcms_core.
module timed_claw_motor_sequencer_top import tcms_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DUR_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_word             i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_word            o_out_word
);

    t_cfg cfg;

    tcms_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tcms_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

// ----- sim/tb_timed_claw_motor_sequencer_top.sv -----
// Self-checking testbench for timed_claw_motor_sequencer_top: directed and random words
// under varying idle/stall mixes, checked against an in-bench claw state predictor.
// Depends on tcms_pkg and the RTL in src.
`timescale 1ns / 1ps

import tcms_pkg::*;

// Predicts each result word from the claw state and keeps the words still owed by the DUT
class claw_scoreboard;
    logic [DUR_W-1:0] open_ms;
    logic [DUR_W-1:0] close_ms;
    t_pos             pos;
    logic [DUR_W-1:0] remaining;
    t_out_word        owed_q[$];
    int               errors;
    int               checked;

    function new();
        open_ms   = '0;
        close_ms  = '0;
        pos       = POS_UNKNOWN;
        remaining = '0;
        errors    = 0;
        checked   = 0;
    endfunction

    function void set_duration(logic [CFG_IDX_W-1:0] idx, logic [DUR_W-1:0] val);
        if (idx == CFG_OPEN_DURATION) begin
            open_ms = val;
        end else if (idx == CFG_CLOSE_DURATION) begin
            close_ms = val;
        end
    endfunction

    function bit moving();
        return (pos == POS_OPENING) || (pos == POS_CLOSING);
    endfunction

    // Any unset duration hides the real position behind the error code
    function t_pos shown_pos();
        if (open_ms == '0 || close_ms == '0) return POS_ERROR;
        return pos;
    endfunction

    function int pending();
        return owed_q.size();
    endfunction

    // Advance the claw state for one accepted input word and queue the owed result
    function void note_input(t_in_word w);
        t_err      err;
        t_pos      here;
        t_pos      dest;
        t_pos      travel;
        t_pos      origin;
        t_out_word res;
        err = ERR_NONE;
        case (w.func)
            FUNC_TICK: begin
                if (moving()) begin
                    if (remaining != '0) remaining = remaining - DUR_W'(1);
                    if (remaining == '0) begin
                        if (pos == POS_OPENING) pos = POS_OPENED;
                        else pos = POS_CLOSED;
                    end
                end
            end
            FUNC_OPEN, FUNC_CLOSE: begin
                if (w.func == FUNC_OPEN) begin
                    dest   = POS_OPENED;
                    travel = POS_OPENING;
                    origin = POS_CLOSED;
                end else begin
                    dest   = POS_CLOSED;
                    travel = POS_CLOSING;
                    origin = POS_OPENED;
                end
                here = shown_pos();
                if (w.kill_asserted) begin
                    err = ERR_KILL;
                end else if (here == dest || here == travel) begin
                    err = ERR_NONE;
                end else if (here != POS_UNKNOWN && here != origin) begin
                    err = ERR_INVALID;
                end else begin
                    pos = travel;
                    if (w.func == FUNC_OPEN) remaining = open_ms;
                    else remaining = close_ms;
                end
            end
            default: begin
                // safety disable: a moving claw ends up at an unknown spot
                if (moving()) begin
                    pos       = POS_UNKNOWN;
                    remaining = '0;
                end
            end
        endcase
        res.ok              = (err == ERR_NONE);
        res.error_code      = err;
        res.position_report = shown_pos();
        res.busy_res        = moving();
        res.motor_enable    = moving();
        res.motor_forward   = (pos == POS_OPENING);
        owed_q.push_back(res);
    endfunction

    function void check_field(string name, logic [2:0] want, logic [2:0] got);
        if (got !== want) begin
            $error("field %s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    function void check_result(t_out_word got);
        t_out_word want;
        if (owed_q.size() == 0) begin
            $error("result word %h arrived with nothing expected", got);
            errors++;
            return;
        end
        want = owed_q.pop_front();
        checked++;
        check_field("ok", want.ok, got.ok);
        check_field("error_code", want.error_code, got.error_code);
        check_field("position_report", want.position_report, got.position_report);
        check_field("busy_res", want.busy_res, got.busy_res);
        check_field("motor_enable", want.motor_enable, got.motor_enable);
        check_field("motor_forward", want.motor_forward, got.motor_forward);
    endfunction
endclass

module tb_timed_claw_motor_sequencer_top;

    localparam int STUCK_LIMIT = 2000;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DUR_W-1:0]     i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    t_in_word             i_in_word   = '0;
    logic                 i_out_stall = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_word            o_out_word;

    claw_scoreboard sb;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int words_sent  = 0;
    int cfg_writes  = 0;
    int stuck       = 0;

    timed_claw_motor_sequencer_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always #5 i_clk = ~i_clk;

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_word);
    end

    // Watchdog: cycles without any handshake on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stuck <= 0;
        end else begin
            stuck <= stuck + 1;
        end
        if (stuck >= STUCK_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Present one input word after a random sender gap, hold it until taken
    task automatic send_word(t_func f, logic kill);
        t_in_word w;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        w.func          = f;
        w.kill_asserted = kill;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(w);
        words_sent++;
    endtask

    // Let every owed result come back, then let the pipeline settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Both duration registers, back to back on one held valid
    task automatic write_durations(logic [DUR_W-1:0] open_val, logic [DUR_W-1:0] close_val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_OPEN_DURATION;
        i_cfg_data  <= open_val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_duration(CFG_OPEN_DURATION, open_val);
        i_cfg_index <= CFG_CLOSE_DURATION;
        i_cfg_data  <= close_val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_duration(CFG_CLOSE_DURATION, close_val);
        i_cfg_valid <= 1'b0;
        cfg_writes += 2;
    endtask

    // Mostly ticks and open/close so moves run to completion; some kill and disable noise
    task automatic run_random(int count);
        int    r;
        t_func f;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 50) f = FUNC_TICK;
            else if (r < 68) f = FUNC_OPEN;
            else if (r < 86) f = FUNC_CLOSE;
            else f = FUNC_DISABLE;
            send_word(f, ($urandom_range(0, 9) == 0));
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender sparse gaps, receiver stalls often
        tx_idle_pct = 14;
        rx_idle_pct = 66;

        // Durations still unset after reset: error position, open/close refused
        send_word(FUNC_OPEN, 1'b0);
        send_word(FUNC_CLOSE, 1'b0);
        send_word(FUNC_TICK, 1'b0);
        send_word(FUNC_DISABLE, 1'b0);
        send_word(FUNC_OPEN, 1'b1);

        drain();
        write_durations(16'd3, 16'd2);
        send_word(FUNC_OPEN, 1'b1);     // kill refuses
        send_word(FUNC_OPEN, 1'b0);     // from unknown
        send_word(FUNC_OPEN, 1'b0);     // already opening
        send_word(FUNC_CLOSE, 1'b0);    // wrong direction
        send_word(FUNC_TICK, 1'b0);
        send_word(FUNC_TICK, 1'b0);
        send_word(FUNC_TICK, 1'b0);     // countdown done, opened
        send_word(FUNC_OPEN, 1'b0);     // already there
        send_word(FUNC_TICK, 1'b0);     // tick while stopped
        send_word(FUNC_CLOSE, 1'b0);    // from opened
        send_word(FUNC_OPEN, 1'b0);     // wrong direction
        send_word(FUNC_DISABLE, 1'b1);  // stop mid-move, kill ignored
        send_word(FUNC_DISABLE, 1'b0);  // disable while stopped
        send_word(FUNC_CLOSE, 1'b0);
        send_word(FUNC_TICK, 1'b1);     // tick ignores kill
        send_word(FUNC_TICK, 1'b0);
        send_word(FUNC_CLOSE, 1'b1);
        send_word(FUNC_OPEN, 1'b0);     // from closed
        send_word(FUNC_TICK, 1'b0);

        // Random phases; durations change while the claw may still be moving
        drain();
        write_durations(DUR_W'($urandom_range(1, 12)), DUR_W'($urandom_range(1, 12)));
        run_random(350);
        drain();
        write_durations(16'd1, 16'd1);
        run_random(250);

        // Sender idles often, receiver rarely
        tx_idle_pct = 66;
        rx_idle_pct = 14;
        drain();
        write_durations(16'hFFFF, 16'hFFFF);
        run_random(120);
        drain();
        write_durations(16'd0, DUR_W'($urandom_range(1, 8)));
        run_random(60);
        drain();
        write_durations(DUR_W'($urandom_range(1, 8)), 16'd0);
        run_random(60);

        // Full rate both ways
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        drain();
        write_durations(DUR_W'($urandom_range(1, 16)), DUR_W'($urandom_range(1, 16)));
        run_random(450);
        drain();

        if (sb.pending() != 0) begin
            $error("%0d result words never arrived", sb.pending());
            sb.errors++;
        end
        $display("tb: %0d words sent, %0d results checked, %0d duration writes",
                 words_sent, sb.checked, cfg_writes);
        $display("tb: covered unset, minimum, maximum and random durations under three stall mixes");
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
